// ----- design/sbj_pkg.sv -----
package sbj_pkg;

  // Field and register widths
  localparam int unsigned KEY_W           = 31;
  localparam int unsigned CAP_W           = 32;
  localparam int unsigned PNUM_W          = 32;
  localparam int unsigned OUT_IDX_W       = 6;
  localparam int unsigned OP_W            = 2;
  localparam int unsigned REG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 32;

  // Default sizes
  localparam int unsigned INNER_DEPTH_DEF = 64;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_PROBE   = 2'd1,
    OP_RESTART = 2'd2
  } sbj_op_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BAND_WIDTH      = 1'b0,
    REG_RESULT_CAPACITY = 1'b1
  } sbj_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SCAN
  } sbj_state_e;

  // Command word from the front to the back
  typedef struct packed {
    sbj_op_e           op;
    logic [KEY_W-1:0]  key;
    logic [PNUM_W-1:0] probe;
  } sbj_cmd_t;

  // Result word from the back to the output queue
  typedef struct packed {
    logic [PNUM_W-1:0]    outer_index;
    logic [OUT_IDX_W-1:0] match_pos;
    logic                 last_of_probe;
    logic                 capacity_reached;
  } sbj_res_t;

endpackage

// ----- design/sbj_fifo.sv -----
module sbj_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = sbj_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold the payload words
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- design/sbj_front.sv -----
module sbj_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [sbj_pkg::OP_W-1:0]            opcode_i,
  input  logic [sbj_pkg::KEY_W-1:0]           key_i,
  input  logic                                cmdq_full_i,
  output logic                                cmdq_push_o,
  output sbj_pkg::sbj_cmd_t                   cmd_o
);

  logic                        accept;
  logic [sbj_pkg::PNUM_W-1:0]  probe_q, probe_d;
  logic                        keep;

  assign full   = cmdq_full_i;
  assign accept = push && !cmdq_full_i;

  // Classify the word: number probes, drop unused opcodes
  always_comb begin
    probe_d = probe_q;
    keep    = 1'b0;
    unique case (opcode_i)
      sbj_pkg::OP_LOAD: begin
        keep = 1'b1;
      end
      sbj_pkg::OP_PROBE: begin
        keep = 1'b1;
        if (accept) begin
          probe_d = probe_q + 1'b1;
        end
      end
      sbj_pkg::OP_RESTART: begin
        keep = 1'b1;
        if (accept) begin
          probe_d = '0;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign cmdq_push_o = accept && keep;
  assign cmd_o.op    = sbj_pkg::sbj_op_e'(opcode_i);
  assign cmd_o.key   = key_i;
  assign cmd_o.probe = probe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

endmodule

// ----- design/sbj_back.sv -----
module sbj_back #(
  parameter int unsigned INNER_DEPTH = sbj_pkg::INNER_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sbj_pkg::REG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sbj_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                cmd_empty_i,
  input  sbj_pkg::sbj_cmd_t                   cmd_i,
  output logic                                cmd_pop_o,
  input  logic                                res_full_i,
  output logic                                res_push_o,
  output sbj_pkg::sbj_res_t                   res_o
);

  localparam int unsigned IDX_W = (INNER_DEPTH > 1) ? $clog2(INNER_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(INNER_DEPTH + 1);
  localparam int unsigned KEY_W = sbj_pkg::KEY_W;
  localparam int unsigned CAP_W = sbj_pkg::CAP_W;

  sbj_pkg::sbj_state_e state_q, state_d;

  logic [KEY_W-1:0]          band_q;
  logic [CAP_W-1:0]          cap_q;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [CAP_W-1:0]          total_q, total_d;
  logic [CNT_W-1:0]          left_q, left_d;
  logic [CNT_W-1:0]          right_q, right_d;
  logic [CNT_W-1:0]          idx_q, idx_d;
  logic [KEY_W+1:0]          lo_q, lo_d;
  logic [KEY_W:0]            hi_q, hi_d;
  logic [sbj_pkg::PNUM_W-1:0] pnum_q, pnum_d;
  logic                      pend_q, pend_d;
  logic [IDX_W-1:0]          pend_idx_q, pend_idx_d;
  logic                      pend_cap_q, pend_cap_d;

  logic [KEY_W-1:0]          keys_q [INNER_DEPTH];
  logic [KEY_W-1:0]          rdata_q;
  logic [IDX_W-1:0]          rd_addr;
  logic                      we;

  logic [CNT_W:0]            mid_cur_sum, mid_nxt_sum;
  logic [CNT_W-1:0]          mid_cur;
  logic                      key_ge_lo, key_le_hi, below_cap, cont, last;

  assign mid_cur_sum = {1'b0, left_q} + {1'b0, right_q};
  assign mid_cur     = mid_cur_sum[CNT_W:1];
  assign mid_nxt_sum = {1'b0, left_d} + {1'b0, right_d};
  assign key_ge_lo   = $signed({2'b00, rdata_q}) >= $signed(lo_q);
  assign key_le_hi   = {1'b0, rdata_q} <= hi_q;
  assign below_cap   = total_q < cap_q;
  assign cont        = (idx_q < count_q) && key_le_hi && below_cap;

  // Sequence loads, restarts, search and scan
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    total_d    = total_q;
    left_d     = left_q;
    right_d    = right_q;
    idx_d      = idx_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    pnum_d     = pnum_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    pend_cap_d = pend_cap_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    last       = 1'b0;
    we         = 1'b0;
    unique case (state_q)
      sbj_pkg::ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            sbj_pkg::OP_LOAD: begin
              if (count_q < CNT_W'(INNER_DEPTH)) begin
                we      = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            sbj_pkg::OP_RESTART: begin
              count_d = '0;
              total_d = '0;
            end
            sbj_pkg::OP_PROBE: begin
              pnum_d = cmd_i.probe;
              lo_d   = {2'b00, cmd_i.key} - {2'b00, band_q};
              hi_d   = {1'b0, cmd_i.key} + {1'b0, band_q};
              if (below_cap) begin
                left_d  = '0;
                right_d = count_q;
                state_d = sbj_pkg::ST_SRCH;
              end
            end
            default: begin
              state_d = sbj_pkg::ST_IDLE;
            end
          endcase
        end
      end
      sbj_pkg::ST_SRCH: begin
        // rdata_q holds the key at the current midpoint
        if (left_q < right_q) begin
          if (key_ge_lo) begin
            right_d = mid_cur;
          end else begin
            left_d = mid_cur + 1'b1;
          end
        end else begin
          idx_d   = right_q;
          state_d = sbj_pkg::ST_SCAN;
        end
      end
      sbj_pkg::ST_SCAN: begin
        // A pending pair leaves once the next key decides whether it is the last
        if (!(pend_q && res_full_i)) begin
          res_push_o = pend_q;
          last       = !cont;
          if (cont) begin
            pend_d     = 1'b1;
            pend_idx_d = idx_q[IDX_W-1:0];
            pend_cap_d = ({1'b0, total_q} + 1'b1) == {1'b0, cap_q};
            total_d    = total_q + 1'b1;
            idx_d      = idx_q + 1'b1;
          end else begin
            pend_d  = 1'b0;
            state_d = sbj_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = sbj_pkg::ST_IDLE;
      end
    endcase
  end

  // Present the next read address so the key is ready in the following cycle
  always_comb begin
    if (state_d == sbj_pkg::ST_SRCH) begin
      rd_addr = mid_nxt_sum[IDX_W:1];
    end else begin
      rd_addr = idx_d[IDX_W-1:0];
    end
  end

  assign res_o.outer_index      = pnum_q;
  assign res_o.match_pos        = sbj_pkg::OUT_IDX_W'(pend_idx_q);
  assign res_o.last_of_probe    = last;
  assign res_o.capacity_reached = pend_cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbj_pkg::ST_IDLE;
      count_q <= '0;
      total_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      total_q <= total_d;
      pend_q  <= pend_d;
    end
  end

  // Hold the search and scan working registers
  always_ff @(posedge clk_i) begin
    left_q     <= left_d;
    right_q    <= right_d;
    idx_q      <= idx_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    pnum_q     <= pnum_d;
    pend_idx_q <= pend_idx_d;
    pend_cap_q <= pend_cap_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q <= '0;
      cap_q  <= '1;
    end else if (cfg_we_i) begin
      unique case (sbj_pkg::sbj_reg_e'(cfg_idx_i))
        sbj_pkg::REG_BAND_WIDTH:      band_q <= cfg_data_i[KEY_W-1:0];
        sbj_pkg::REG_RESULT_CAPACITY: cap_q  <= cfg_data_i[CAP_W-1:0];
        default:                      band_q <= band_q;
      endcase
    end
  end

  // Inner key memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      keys_q[count_q[IDX_W-1:0]] <= cmd_i.key;
    end
    rdata_q <= keys_q[rd_addr];
  end

endmodule

// ----- design/sorted_band_join_probe.sv -----
// Band join probe engine. Words with opcode load append a key to a sorted inner
// table of INNER_DEPTH entries (loads beyond it are dropped), restart clears the
// table, the probe numbering and the emitted total, and probe looks up every
// inner key within band_width of the probe key, giving one result word per match
// in table order, the last one of a probe marked, until the emitted total meets
// result_capacity. A probe that does not find the capacity already met runs a
// lower-bound search over the loaded keys and then scans the matching keys:
// every search step and every scan step is one read of the key memory's single
// read port. A small command queue ahead of the engine and a result queue behind
// it let input and output stall independently; a full result queue holds the
// scan.
module sorted_band_join_probe #(
  parameter int unsigned INNER_DEPTH = sbj_pkg::INNER_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sbj_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sbj_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              push,
  output logic                              full,
  input  logic [sbj_pkg::OP_W-1:0]          opcode_i,
  input  logic [sbj_pkg::KEY_W-1:0]         key_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [sbj_pkg::PNUM_W-1:0]        outer_index_o,
  output logic [sbj_pkg::OUT_IDX_W-1:0]     match_pos_o,
  output logic                              last_of_probe_o,
  output logic                              capacity_reached_o
);

  localparam int unsigned CMD_W = $bits(sbj_pkg::sbj_cmd_t);
  localparam int unsigned RES_W = $bits(sbj_pkg::sbj_res_t);

  sbj_pkg::sbj_cmd_t front_cmd, back_cmd;
  sbj_pkg::sbj_res_t back_res, out_res;
  logic              cmdq_push, cmdq_full, cmdq_pop, cmdq_empty;
  logic              resq_push, resq_full;

  sbj_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .opcode_i    (opcode_i),
    .key_i       (key_i),
    .cmdq_full_i (cmdq_full),
    .cmdq_push_o (cmdq_push),
    .cmd_o       (front_cmd)
  );

  sbj_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (sbj_pkg::QUEUE_DEPTH_DEF)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmdq_push),
    .wdata_i (front_cmd),
    .full_o  (cmdq_full),
    .pop_i   (cmdq_pop),
    .rdata_o (back_cmd),
    .empty_o (cmdq_empty)
  );

  sbj_back #(
    .INNER_DEPTH (INNER_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_empty_i (cmdq_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmdq_pop),
    .res_full_i  (resq_full),
    .res_push_o  (resq_push),
    .res_o       (back_res)
  );

  sbj_fifo #(
    .WIDTH (RES_W),
    .DEPTH (sbj_pkg::QUEUE_DEPTH_DEF)
  ) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (resq_push),
    .wdata_i (back_res),
    .full_o  (resq_full),
    .pop_i   (pop),
    .rdata_o (out_res),
    .empty_o (empty)
  );

  assign outer_index_o      = out_res.outer_index;
  assign match_pos_o        = out_res.match_pos;
  assign last_of_probe_o    = out_res.last_of_probe;
  assign capacity_reached_o = out_res.capacity_reached;

endmodule

// ----- design/sbj_checker.sv -----
module sbj_checker #(
  parameter int unsigned INNER_DEPTH = sbj_pkg::INNER_DEPTH_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              empty,
  input logic                              pop,
  input logic [sbj_pkg::PNUM_W-1:0]        outer_index_o,
  input logic [sbj_pkg::OUT_IDX_W-1:0]     match_pos_o,
  input logic                              last_of_probe_o,
  input logic                              capacity_reached_o
);

  // A waiting result word holds until taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(outer_index_o) && $stable(match_pos_o)
      && $stable(last_of_probe_o) && $stable(capacity_reached_o))
    else $error("result word changed while waiting");

  // The pair that meets the capacity ends its probe
  a_cap_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && capacity_reached_o |-> last_of_probe_o)
    else $error("capacity reached on a pair not marked last");

  // Matches only come from positions within the table depth
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (32'(match_pos_o) < INNER_DEPTH))
    else $error("match position beyond table depth");

endmodule

bind sorted_band_join_probe sbj_checker #(.INNER_DEPTH(INNER_DEPTH)) u_sbj_checker (.*);
